// ===== sv/sfms_pkg.sv =====
`timescale 1ns / 1ps

package sfms_pkg;

    // transform length, a power of two from 4 to 128
    localparam int FFT_SIZE = 128;
    localparam int ADDR_W   = $clog2(FFT_SIZE);
    localparam int HALF     = FFT_SIZE / 2;
    localparam int STAGE_W  = (ADDR_W > 2) ? $clog2(ADDR_W) : 1;
    localparam int WORK_W   = 24;
    localparam int PROD_W   = 2 * WORK_W;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [ADDR_W-2:0]        bin_t;
    typedef logic [ADDR_W:0]          cnt_t;
    typedef logic [STAGE_W-1:0]       stage_t;
    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [16:0]       twiddle_t;

    localparam cnt_t   FULL_COUNT = cnt_t'(FFT_SIZE);
    localparam stage_t LAST_STAGE = stage_t'(ADDR_W - 1);
    localparam bin_t   LAST_BIN   = bin_t'(HALF - 1);

    // quarter wave of sin(2*pi*k/128) in q1.15, 1.0 stored as 32768
    localparam logic [16:0] QSINE [33] = '{
        17'd0,     17'd1608,  17'd3212,  17'd4808,  17'd6393,  17'd7962,  17'd9512,
        17'd11039, 17'd12540, 17'd14010, 17'd15447, 17'd16846, 17'd18205, 17'd19520,
        17'd20788, 17'd22006, 17'd23170, 17'd24279, 17'd25330, 17'd26320, 17'd27246,
        17'd28106, 17'd28899, 17'd29622, 17'd30274, 17'd30853, 17'd31357, 17'd31786,
        17'd32138, 17'd32413, 17'd32610, 17'd32729, 17'd32768
    };

    function automatic twiddle_t rom_sin(input logic [5:0] k);
        logic [6:0] idx;
        idx = (k <= 6'd32) ? {1'b0, k} : (7'd64 - {1'b0, k});
        return twiddle_t'(QSINE[idx[5:0]]);
    endfunction

    function automatic twiddle_t rom_cos(input logic [5:0] k);
        logic [5:0] idx;
        twiddle_t   v;
        idx = (k <= 6'd32) ? (6'd32 - k) : (k - 6'd32);
        v   = twiddle_t'(QSINE[idx]);
        return (k <= 6'd32) ? v : -v;
    endfunction

    function automatic addr_t rev_bits(input addr_t v);
        addr_t r;
        for (int b = 0; b < ADDR_W; b++)
        begin
            r[b] = v[ADDR_W-1-b];
        end
        return r;
    endfunction

endpackage

// ===== sv/sfms_ram.sv =====
`timescale 1ns / 1ps

module sfms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sliding_fft_magnitude_spectrum.sv =====
`timescale 1ns / 1ps
// channel  | handshake                   | payload
// sample   | sample_valid / sample_ready | sample_value, run_transform
// bin      | bin_valid / bin_ready       | bin_index, magnitude, last_bin
//
// a plain sample is written to the window and the block stays ready; a marked sample starts the transform
// transform: a bit-reversed load of the window, then the butterflies on the shared multiplier,
// then per bin a read, squaring, a square root of 24 result bits and an emit step
// sample_ready stays low throughout
// reset clears the window fill count, so the window reads as all zero
// a stalled bin beat holds the sequencer in its emit step

module sliding_fft_magnitude_spectrum (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [15:0] sample_value,
    input  logic        run_transform,
    output logic        bin_valid,
    input  logic        bin_ready,
    output logic [5:0]  bin_index,
    output logic [15:0] magnitude,
    output logic        last_bin
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_LD_RD, ST_LD_WR,
        ST_BF_RB, ST_BF_RA, ST_BF_LA, ST_BF_P2, ST_BF_P3, ST_BF_P4, ST_BF_P5,
        ST_BF_WB, ST_BF_WA,
        ST_MG_RD, ST_MG_SQ1, ST_MG_SQ2, ST_MG_SQ3, ST_MG_SQRT, ST_MG_EMIT
    } state_t;

    state_t state_reg, state_next;

    sfms_pkg::addr_t  i_reg, i_next;
    logic             zero_reg, zero_next;
    sfms_pkg::stage_t s_reg, s_next;
    sfms_pkg::bin_t   j_reg, j_next;
    sfms_pkg::addr_t  a_reg, a_next;
    sfms_pkg::bin_t   bin_reg, bin_next;
    sfms_pkg::addr_t  wp_reg, wp_next;
    sfms_pkg::cnt_t   count_reg, count_next;
    sfms_pkg::work_t  br_reg, br_next, bi_reg, bi_next;
    sfms_pkg::work_t  ar_reg, ar_next, ai_reg, ai_next;
    sfms_pkg::work_t  tr_reg, tr_next, ti_reg, ti_next;
    sfms_pkg::prod_t  prod_reg, prod_next, acc_reg, acc_next;
    logic [47:0]      x_reg, x_next, res_reg, res_next, bit_reg, bit_next;
    logic             out_valid_reg, out_valid_next;
    logic [5:0]       out_index_reg, out_index_next;
    logic [15:0]      out_mag_reg, out_mag_next;
    logic             out_last_reg, out_last_next;

    // memory ports
    logic             win_we;
    sfms_pkg::addr_t  win_raddr;
    logic [15:0]      win_rdata;
    logic             wk_we;
    sfms_pkg::addr_t  wk_waddr, wk_raddr;
    sfms_pkg::work_t  wk_wre, wk_wim;
    logic [23:0]      wk_rre, wk_rim;

    // datapath helpers
    sfms_pkg::addr_t    h_val, b_addr, rev_i;
    logic [sfms_pkg::ADDR_W:0] a_step;
    logic [5:0]         tw_k;
    sfms_pkg::twiddle_t tw_c, tw_s;
    sfms_pkg::work_t    tw_c_w, tw_s_w;
    sfms_pkg::work_t    mul_a, mul_b;
    sfms_pkg::prod_t    sum_val, rnd_val;
    logic [48:0]        trial;
    logic [24:0]        mag_sum, mag_shift;
    logic               accept_in;

    assign accept_in    = sample_valid && sample_ready;
    assign sample_ready = (state_reg == ST_IDLE);
    assign bin_valid    = out_valid_reg;
    assign bin_index    = out_index_reg;
    assign magnitude    = out_mag_reg;
    assign last_bin     = out_last_reg;

    sfms_ram #(.WIDTH(16), .DEPTH(sfms_pkg::FFT_SIZE)) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (wp_reg),
        .wdata (sample_value),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    sfms_ram #(.WIDTH(sfms_pkg::WORK_W), .DEPTH(sfms_pkg::FFT_SIZE)) u_work_re (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wre),
        .raddr (wk_raddr),
        .rdata (wk_rre)
    );

    sfms_ram #(.WIDTH(sfms_pkg::WORK_W), .DEPTH(sfms_pkg::FFT_SIZE)) u_work_im (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wim),
        .raddr (wk_raddr),
        .rdata (wk_rim)
    );

    // butterfly addressing and twiddle lookup
    assign h_val  = {{(sfms_pkg::ADDR_W-1){1'b0}}, 1'b1} << s_reg;
    assign b_addr = a_reg + h_val;
    assign a_step = {1'b0, a_reg} + ({1'b0, h_val} << 1);
    assign rev_i  = sfms_pkg::rev_bits(i_reg);
    assign tw_k   = 6'(7'(j_reg) << (3'd6 - 3'(s_reg)));
    assign tw_c   = sfms_pkg::rom_cos(tw_k);
    assign tw_s   = sfms_pkg::rom_sin(tw_k);
    assign tw_c_w = {{7{tw_c[16]}}, tw_c};
    assign tw_s_w = {{7{tw_s[16]}}, tw_s};

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_BF_LA:  begin mul_a = tw_c_w; mul_b = br_reg; end
            ST_BF_P2:  begin mul_a = tw_s_w; mul_b = bi_reg; end
            ST_BF_P3:  begin mul_a = tw_c_w; mul_b = bi_reg; end
            ST_BF_P4:  begin mul_a = tw_s_w; mul_b = br_reg; end
            ST_MG_SQ1: begin mul_a = wk_rre; mul_b = wk_rre; end
            ST_MG_SQ2: begin mul_a = bi_reg; mul_b = bi_reg; end
            default:   begin mul_a = '0;     mul_b = '0;     end
        endcase
    end

    assign sum_val   = (state_reg == ST_BF_P5) ? (acc_reg - prod_reg) : (acc_reg + prod_reg);
    assign rnd_val   = sum_val + 48'sd16384;
    assign trial     = {1'b0, res_reg} + {1'b0, bit_reg};
    assign mag_sum   = {1'b0, res_reg[23:0]} + 25'(sfms_pkg::HALF);
    assign mag_shift = mag_sum >> sfms_pkg::ADDR_W;

    // sequencer next state and memory controls
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        zero_next      = zero_reg;
        s_next         = s_reg;
        j_next         = j_reg;
        a_next         = a_reg;
        bin_next       = bin_reg;
        wp_next        = wp_reg;
        count_next     = count_reg;
        br_next        = br_reg;
        bi_next        = bi_reg;
        ar_next        = ar_reg;
        ai_next        = ai_reg;
        tr_next        = tr_reg;
        ti_next        = ti_reg;
        prod_next      = mul_a * mul_b;
        acc_next       = acc_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !bin_ready;
        out_index_next = out_index_reg;
        out_mag_next   = out_mag_reg;
        out_last_next  = out_last_reg;
        win_we         = 1'b0;
        win_raddr      = wp_reg + rev_i;
        wk_we          = 1'b0;
        wk_waddr       = a_reg;
        wk_raddr       = a_reg;
        wk_wre         = ar_reg + tr_reg;
        wk_wim         = ai_reg + ti_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    win_we  = 1'b1;
                    wp_next = wp_reg + 1'b1;
                    if (count_reg != sfms_pkg::FULL_COUNT)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (run_transform)
                    begin
                        i_next     = '0;
                        state_next = ST_LD_RD;
                    end
                end
            end
            // bit-reversed copy of the window into the work stores
            ST_LD_RD:
            begin
                zero_next  = ({1'b0, rev_i} < (sfms_pkg::FULL_COUNT - count_reg));
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                wk_we    = 1'b1;
                wk_waddr = i_reg;
                wk_wre   = zero_reg ? '0 : {{8{win_rdata[15]}}, win_rdata};
                wk_wim   = '0;
                i_next   = i_reg + 1'b1;
                if (i_reg == sfms_pkg::addr_t'(sfms_pkg::FFT_SIZE - 1))
                begin
                    s_next     = '0;
                    j_next     = '0;
                    a_next     = '0;
                    state_next = ST_BF_RB;
                end
                else
                begin
                    state_next = ST_LD_RD;
                end
            end
            // one butterfly
            ST_BF_RB:
            begin
                wk_raddr   = b_addr;
                state_next = ST_BF_RA;
            end
            ST_BF_RA:
            begin
                br_next    = wk_rre;
                bi_next    = wk_rim;
                state_next = ST_BF_LA;
            end
            ST_BF_LA:
            begin
                ar_next    = wk_rre;
                ai_next    = wk_rim;
                state_next = ST_BF_P2;
            end
            ST_BF_P2:
            begin
                acc_next   = prod_reg;
                state_next = ST_BF_P3;
            end
            ST_BF_P3:
            begin
                tr_next    = rnd_val[38:15];
                state_next = ST_BF_P4;
            end
            ST_BF_P4:
            begin
                acc_next   = prod_reg;
                state_next = ST_BF_P5;
            end
            ST_BF_P5:
            begin
                ti_next    = rnd_val[38:15];
                state_next = ST_BF_WB;
            end
            ST_BF_WB:
            begin
                wk_we      = 1'b1;
                wk_waddr   = b_addr;
                wk_wre     = ar_reg - tr_reg;
                wk_wim     = ai_reg - ti_reg;
                state_next = ST_BF_WA;
            end
            ST_BF_WA:
            begin
                wk_we      = 1'b1;
                state_next = ST_BF_RB;
                if (!a_step[sfms_pkg::ADDR_W])
                begin
                    a_next = a_step[sfms_pkg::ADDR_W-1:0];
                end
                else if (({1'b0, j_reg} + 1'b1) != h_val)
                begin
                    j_next = j_reg + 1'b1;
                    a_next = {1'b0, j_reg} + 1'b1;
                end
                else if (s_reg != sfms_pkg::LAST_STAGE)
                begin
                    s_next = s_reg + 1'b1;
                    j_next = '0;
                    a_next = '0;
                end
                else
                begin
                    bin_next   = '0;
                    state_next = ST_MG_RD;
                end
            end
            // magnitude of one bin
            ST_MG_RD:
            begin
                wk_raddr   = {1'b0, bin_reg};
                state_next = ST_MG_SQ1;
            end
            ST_MG_SQ1:
            begin
                bi_next    = wk_rim;
                state_next = ST_MG_SQ2;
            end
            ST_MG_SQ2:
            begin
                acc_next   = prod_reg;
                state_next = ST_MG_SQ3;
            end
            ST_MG_SQ3:
            begin
                x_next     = 48'(sum_val);
                res_next   = '0;
                bit_next   = 48'h1 << 46;
                state_next = ST_MG_SQRT;
            end
            ST_MG_SQRT:
            begin
                if ({1'b0, x_reg} >= trial)
                begin
                    x_next   = x_reg - trial[47:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = ST_MG_EMIT;
                end
            end
            ST_MG_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = 6'(bin_reg);
                    out_mag_next   = (mag_shift > 25'd65535) ? 16'hFFFF : mag_shift[15:0];
                    out_last_next  = (bin_reg == sfms_pkg::LAST_BIN);
                    bin_next       = bin_reg + 1'b1;
                    state_next     = (bin_reg == sfms_pkg::LAST_BIN) ? ST_IDLE : ST_MG_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, window pointer, fill count and output valid, with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        zero_reg      <= zero_next;
        s_reg         <= s_next;
        j_reg         <= j_next;
        a_reg         <= a_next;
        bin_reg       <= bin_next;
        br_reg        <= br_next;
        bi_reg        <= bi_next;
        ar_reg        <= ar_next;
        ai_reg        <= ai_next;
        tr_reg        <= tr_next;
        ti_reg        <= ti_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        x_reg         <= x_next;
        res_reg       <= res_next;
        bit_reg       <= bit_next;
        out_index_reg <= out_index_next;
        out_mag_reg   <= out_mag_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ===== sv/sfms_checker.sv =====
`timescale 1ns / 1ps

module sfms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sample_valid,
    input logic        sample_ready,
    input logic        run_transform,
    input logic        bin_valid,
    input logic        bin_ready,
    input logic [5:0]  bin_index,
    input logic [15:0] magnitude,
    input logic        last_bin
);

    // a stalled bin beat holds
    a_bin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && !bin_ready |=> bin_valid && $stable(bin_index) && $stable(magnitude)
            && $stable(last_bin))
        else $error("bin beat changed while stalled");

    // a marked sample starts the transform
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && run_transform |=> !sample_ready)
        else $error("ready after marked sample");

    // a plain sample leaves the block ready
    a_plain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && !run_transform |=> sample_ready)
        else $error("not ready after plain sample");

    // last flag sits on the top bin only
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid |-> (last_bin == (bin_index == 6'(sfms_pkg::HALF - 1))))
        else $error("last flag on wrong bin");

    // no beat follows the last bin at once
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && bin_ready && last_bin |=> !bin_valid)
        else $error("beat after last bin");

endmodule

bind sliding_fft_magnitude_spectrum sfms_checker u_sfms_checker (.*);

// ===== test/tb_sliding_fft_magnitude_spectrum.sv =====
`timescale 1ns / 1ps

class spectrum_scoreboard;
    logic signed [15:0] window_q [128];
    logic [5:0]  exp_bin_q [$];
    logic [15:0] exp_mag_q [$];
    logic        exp_last_q [$];
    int          mismatches;

    function new();
        for (int i = 0; i < 128; i++)
        begin
            window_q[i] = '0;
        end
        mismatches = 0;
    endfunction

    function automatic longint round15(longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic longint wrap_work(longint v);
        logic signed [23:0] w;
        w = v[23:0];
        return longint'(w);
    endfunction

    function automatic longint qsin(int k);
        int qs [33] = '{0, 1608, 3212, 4808, 6393, 7962, 9512, 11039, 12540, 14010,
            15447, 16846, 18205, 19520, 20788, 22006, 23170, 24279, 25330, 26320,
            27246, 28106, 28899, 29622, 30274, 30853, 31357, 31786, 32138, 32413,
            32610, 32729, 32768};
        k = k & 63;
        return (k <= 32) ? qs[k] : qs[64 - k];
    endfunction

    function automatic longint qcos(int k);
        k = k & 63;
        return (k <= 32) ? qsin(32 - k) : -qsin(k - 32);
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // shift a sample in, compute spectrum when marked
    function void note_sample(logic [15:0] value, logic marked);
        longint re [128];
        longint im [128];
        longint c, s, tr, ti, ar, ai, br, bi, q, m;
        int rev, b;
        for (int i = 0; i < 127; i++)
        begin
            window_q[i] = window_q[i + 1];
        end
        window_q[127] = value;
        if (!marked)
        begin
            return;
        end
        for (int i = 0; i < 128; i++)
        begin
            rev = 0;
            for (int k = 0; k < 7; k++)
            begin
                rev = (rev << 1) | ((i >> k) & 1);
            end
            re[i] = window_q[rev];
            im[i] = 0;
        end
        for (int h = 1; h < 128; h = h << 1)
        begin
            for (int j = 0; j < h; j++)
            begin
                c = qcos((j * 64) / h);
                s = qsin((j * 64) / h);
                for (int a = j; a + h < 128; a += 2 * h)
                begin
                    b = a + h;
                    br = re[b];
                    bi = im[b];
                    tr = round15(c * br + s * bi);
                    ti = round15(c * bi - s * br);
                    ar = re[a];
                    ai = im[a];
                    re[b] = wrap_work(ar - tr);
                    im[b] = wrap_work(ai - ti);
                    re[a] = wrap_work(ar + tr);
                    im[a] = wrap_work(ai + ti);
                end
            end
        end
        for (int i = 0; i < 64; i++)
        begin
            q = int_sqrt(re[i] * re[i] + im[i] * im[i]);
            m = (q + 64) / 128;
            if (m > 65535)
            begin
                m = 65535;
            end
            exp_bin_q.push_back(6'(i));
            exp_mag_q.push_back(16'(m));
            exp_last_q.push_back(i == 63);
        end
    endfunction

    function void check_bin(logic [5:0] idx, logic [15:0] mag, logic lst);
        if (exp_bin_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected bin beat: idx %0d mag %0d last %0b", idx, mag, lst);
            end
            return;
        end
        if (idx !== exp_bin_q[0] || mag !== exp_mag_q[0] || lst !== exp_last_q[0])
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("bin mismatch: exp idx %0d mag %0d last %0b, got idx %0d mag %0d last %0b",
                    exp_bin_q[0], exp_mag_q[0], exp_last_q[0], idx, mag, lst);
            end
        end
        void'(exp_bin_q.pop_front());
        void'(exp_mag_q.pop_front());
        void'(exp_last_q.pop_front());
    endfunction
endclass

module tb_sliding_fft_magnitude_spectrum;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_ready;
    logic [15:0] sample_value;
    logic        run_transform;
    logic        bin_valid;
    logic        bin_ready;
    logic [5:0]  bin_index;
    logic [15:0] magnitude;
    logic        last_bin;

    spectrum_scoreboard spectra;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_off_cycles;
    bit  hold_go;
    bit  hold_used;
    longint cycle_count;

    sliding_fft_magnitude_spectrum dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample_value  (sample_value),
        .run_transform (run_transform),
        .bin_valid     (bin_valid),
        .bin_ready     (bin_ready),
        .bin_index     (bin_index),
        .magnitude     (magnitude),
        .last_bin      (last_bin)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // offer one sample beat, wait for acceptance
    task automatic send_sample(logic [15:0] value, logic marked);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid  <= 1'b1;
        sample_value  <= value;
        run_transform <= marked;
        @(posedge clk);
        while (!sample_ready)
        begin
            @(posedge clk);
        end
        spectra.note_sample(value, marked);
    endtask

    task automatic send_random(int count, int mark_pct);
        logic [15:0] v;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0: v = $urandom_range(1) ? 16'h7fff : 16'h8000;
                1: v = 16'($signed($urandom_range(511)) - 256);
                default: v = 16'($urandom);
            endcase
            send_sample(v, $urandom_range(99) < mark_pct);
        end
    endtask

    // receiver ready with random idling and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_ready       <= 1'b0;
            hold_off_cycles <= 0;
            hold_used       <= 1'b0;
        end
        else if (hold_go && !hold_used)
        begin
            hold_off_cycles <= 20000;
            hold_used       <= 1'b1;
            bin_ready       <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            bin_ready <= 1'b0;
        end
        else
        begin
            bin_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // bin beat checker
    always @(posedge clk)
    begin
        if (rst_n && bin_valid && bin_ready)
        begin
            spectra.check_bin(bin_index, magnitude, last_bin);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000)
        begin
            $display("sliding_fft_magnitude_spectrum regression: fail");
            $finish;
        end
    end

    initial
    begin
        spectra       = new();
        cycle_count   = 0;
        hold_go       = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 81;
        rst_n         = 1'b0;
        sample_valid  = 1'b0;
        sample_value  = '0;
        run_transform = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: transform of empty window, impulse, full-scale extremes
        send_sample(16'h0000, 1'b1);
        send_sample(16'h7fff, 1'b1);
        for (int i = 0; i < 8; i++)
        begin
            send_sample(16'h8000, 1'b0);
        end
        send_sample(16'h8000, 1'b1);
        for (int i = 0; i < 8; i++)
        begin
            send_sample((i % 2) ? 16'h7fff : 16'h8000, 1'b0);
        end
        send_sample(16'hffff, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'haaaa, 1'b1);

        // long receiver hold-off while samples keep coming
        hold_go = 1'b1;
        send_random(10, 30);

        send_random(60, 4);
        send_idle_pct = 81;
        recv_idle_pct = 34;
        send_random(60, 4);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(60, 4);
        send_sample(16'($urandom), 1'b1);
        sample_valid <= 1'b0;

        while (spectra.exp_bin_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (spectra.mismatches == 0)
        begin
            $display("sliding_fft_magnitude_spectrum regression: pass");
        end
        else
        begin
            $display("sliding_fft_magnitude_spectrum regression: fail");
        end
        $finish;
    end
endmodule
